// File: rtl/qnl_pkg.sv
// Package for the quaternion normalised blend.
// Holds the fixed widths, constants and flag struct shared by the interfaces, pipeline, top and testbench.
// No dependencies.
package qnl_pkg;

  // Blend weight, Q1.16 with one at 2^16
  localparam int WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Degenerate threshold register, Q2.30
  localparam int THR_W = 32;
  localparam logic [THR_W-1:0] THR_RESET = 32'd10737;

  // Blend magnitude in Q.30 (below 2^30), squares and their sum
  localparam int INNER_FRAC = 30;
  localparam int MAG_W = 30;
  localparam int SQ_W = 2 * MAG_W;
  localparam int SUM_W = 62;

  // Magnitude after normalisation, raw and rounded root, root remainder
  localparam int NMAG_W = 31;
  localparam int RAW_ROOT_W = 31;
  localparam int ROOT_W = 32;
  localparam int REM_W = 33;

  // Lanes: x, y, z, w
  localparam int LANES = 4;

  // Per-item flags that travel with the data
  typedef struct packed {
    logic bypass;
    logic degenerate;
    logic [LANES-1:0] neg;
  } qnl_flags_t;

  localparam int FLAGS_W = $bits(qnl_flags_t);

endpackage

// File: rtl/qnl_if.sv
// Valid/ready channel interfaces for the quaternion normalised blend.
// Depends on qnl_pkg for the weight width.
interface qnl_in_if import qnl_pkg::*; #(parameter int COMPONENT_BITS = 16) ();
  logic valid;
  logic ready;
  logic signed [COMPONENT_BITS-1:0] first_x;
  logic signed [COMPONENT_BITS-1:0] first_y;
  logic signed [COMPONENT_BITS-1:0] first_z;
  logic signed [COMPONENT_BITS-1:0] first_w;
  logic signed [COMPONENT_BITS-1:0] second_x;
  logic signed [COMPONENT_BITS-1:0] second_y;
  logic signed [COMPONENT_BITS-1:0] second_z;
  logic signed [COMPONENT_BITS-1:0] second_w;
  logic [WEIGHT_W-1:0] weight;

  modport source (
    output valid, first_x, first_y, first_z, first_w,
    output second_x, second_y, second_z, second_w, weight,
    input ready
  );
  modport sink (
    input valid, first_x, first_y, first_z, first_w,
    input second_x, second_y, second_z, second_w, weight,
    output ready
  );
endinterface

interface qnl_out_if #(parameter int COMPONENT_BITS = 16) ();
  logic valid;
  logic ready;
  logic signed [COMPONENT_BITS-1:0] out_x;
  logic signed [COMPONENT_BITS-1:0] out_y;
  logic signed [COMPONENT_BITS-1:0] out_z;
  logic signed [COMPONENT_BITS-1:0] out_w;
  logic degenerate;

  modport source (output valid, out_x, out_y, out_z, out_w, degenerate, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, degenerate, output ready);
endinterface

// File: rtl/qnl_front.sv
// Front pipeline: clamp, dot product, blend, round, squares, sum, threshold
// check and normalising shift. Eight register stages. Depends on qnl_pkg.
module qnl_front import qnl_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [COMPONENT_BITS-1:0] first [LANES],
  input  logic signed [COMPONENT_BITS-1:0] second [LANES],
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [THR_W-1:0] threshold,
  output logic out_valid,
  output logic [SUM_W-1:0] norm_sum,
  output logic [NMAG_W-1:0] mag [LANES],
  output qnl_flags_t flags,
  output logic [LANES*COMPONENT_BITS-1:0] byp
);

  localparam int CB = COMPONENT_BITS;
  localparam int F = CB - 1;
  localparam int PW = CB + 18;
  localparam int DW = 2 * CB + 2;
  localparam int SH = CB - 1 + 16 - INNER_FRAC;
  localparam int NSH = (SH < 0) ? -SH : 0;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {F{1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {F{1'b0}}};

  // Stage registers
  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [CB-1:0] a1 [LANES];
  logic signed [CB-1:0] c1 [LANES];
  logic [WEIGHT_W-1:0] wa1, wb1;
  logic bp1, bp2, bp3;
  logic [LANES*CB-1:0] bv1, bv2, bv3, bv4, bv5, bv6, bv7;
  logic signed [DW-1:0] dp2 [LANES];
  logic signed [PW-1:0] pa2 [LANES];
  logic signed [PW-1:0] pc2 [LANES];
  logic signed [PW-1:0] pa3 [LANES];
  logic signed [PW-1:0] pc3 [LANES];
  logic flip3;
  logic [MAG_W-1:0] mag4 [LANES];
  logic [MAG_W-1:0] mag5 [LANES];
  logic [MAG_W-1:0] mag6 [LANES];
  logic [SQ_W-1:0] sq5 [LANES];
  logic [SUM_W-1:0] sum6, sum7;
  logic [NMAG_W-1:0] nm7 [LANES];
  qnl_flags_t fl4, fl5, fl6, fl7;

  // Combinational values
  logic signed [CB-1:0] ca [LANES];
  logic signed [CB-1:0] cc [LANES];
  logic [WEIGHT_W-1:0] wcl;
  logic signed [DW-1:0] dot;
  logic [PW-1:0] blabs [LANES];
  logic [LANES-1:0] blneg;
  logic [MAG_W-1:0] mag_c [LANES];
  logic [SUM_W-1:0] sum_c, s7_c, s8_c;
  logic [NMAG_W-1:0] m7_c [LANES];
  logic [NMAG_W-1:0] m8_c [LANES];

  // Clamp the most negative code and weights above one
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ca[i] = (first[i] == CMIN) ? -CMAX : first[i];
      cc[i] = (second[i] == CMIN) ? -CMAX : second[i];
    end
    wcl = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  end

  // Dot product sign
  always_comb begin
    dot = '0;
    for (int i = 0; i < LANES; i++) dot = dot + dp2[i];
  end

  // Blend and its magnitude
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic signed [PW-1:0] bl;
      bl = pa3[i] + (flip3 ? -pc3[i] : pc3[i]);
      blneg[i] = bl[PW-1];
      blabs[i] = bl[PW-1] ? $unsigned(-bl) : $unsigned(bl);
    end
  end

  // Round to Q.30, half away from zero
  for (genvar g = 0; g < LANES; g++) begin : g_round
    if (SH > 0) begin : g_down
      logic [PW:0] rnd;
      assign rnd = {1'b0, blabs[g]} + ((PW + 1)'(1) << (SH - 1));
      assign mag_c[g] = rnd[SH +: MAG_W];
    end else begin : g_up
      logic [MAG_W+PW-1:0] ext;
      assign ext = {{MAG_W{1'b0}}, blabs[g]} << NSH;
      assign mag_c[g] = ext[MAG_W-1:0];
    end
  end

  // Sum of squares
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < LANES; i++) sum_c = sum_c + SUM_W'(sq5[i]);
  end

  // Normalising shift, first half: 16, 8 and 4 places
  always_comb begin
    s7_c = sum6;
    for (int i = 0; i < LANES; i++) m7_c[i] = NMAG_W'(mag6[i]);
    if (s7_c[SUM_W-1:30] == '0) begin
      s7_c = s7_c << 32;
      for (int i = 0; i < LANES; i++) m7_c[i] = m7_c[i] << 16;
    end
    if (s7_c[SUM_W-1:46] == '0) begin
      s7_c = s7_c << 16;
      for (int i = 0; i < LANES; i++) m7_c[i] = m7_c[i] << 8;
    end
    if (s7_c[SUM_W-1:54] == '0) begin
      s7_c = s7_c << 8;
      for (int i = 0; i < LANES; i++) m7_c[i] = m7_c[i] << 4;
    end
  end

  // Normalising shift, second half: 2 and 1 places
  always_comb begin
    s8_c = sum7;
    for (int i = 0; i < LANES; i++) m8_c[i] = nm7[i];
    if (s8_c[SUM_W-1:58] == '0) begin
      s8_c = s8_c << 4;
      for (int i = 0; i < LANES; i++) m8_c[i] = m8_c[i] << 2;
    end
    if (s8_c[SUM_W-1:60] == '0) begin
      s8_c = s8_c << 2;
      for (int i = 0; i < LANES; i++) m8_c[i] = m8_c[i] << 1;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; out_valid <= v7;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: clamped inputs and weights
      for (int i = 0; i < LANES; i++) begin
        a1[i] <= ca[i];
        c1[i] <= cc[i];
        bv1[i*CB +: CB] <= (wcl == WEIGHT_ONE) ? cc[i] : ca[i];
      end
      wb1 <= wcl;
      wa1 <= WEIGHT_ONE - wcl;
      bp1 <= (wcl == '0) || (wcl == WEIGHT_ONE);
      // Stage 2: products
      for (int i = 0; i < LANES; i++) begin
        dp2[i] <= DW'(a1[i]) * DW'(c1[i]);
        pa2[i] <= PW'($signed({1'b0, wa1})) * PW'(a1[i]);
        pc2[i] <= PW'($signed({1'b0, wb1})) * PW'(c1[i]);
      end
      bp2 <= bp1;
      bv2 <= bv1;
      // Stage 3: shortest-path decision
      pa3 <= pa2;
      pc3 <= pc2;
      flip3 <= dot < 0;
      bp3 <= bp2;
      bv3 <= bv2;
      // Stage 4: rounded blend magnitudes
      mag4 <= mag_c;
      fl4.bypass <= bp3;
      fl4.degenerate <= 1'b0;
      fl4.neg <= blneg;
      bv4 <= bv3;
      // Stage 5: squares
      for (int i = 0; i < LANES; i++) sq5[i] <= mag4[i] * mag4[i];
      mag5 <= mag4;
      fl5 <= fl4;
      bv5 <= bv4;
      // Stage 6: sum and threshold
      sum6 <= sum_c;
      mag6 <= mag5;
      fl6.bypass <= fl5.bypass;
      fl6.neg <= fl5.neg;
      fl6.degenerate <= sum_c <= {threshold, {INNER_FRAC{1'b0}}};
      bv6 <= bv5;
      // Stage 7 and 8: normalisation
      sum7 <= s7_c;
      nm7 <= m7_c;
      fl7 <= fl6;
      bv7 <= bv6;
      norm_sum <= s8_c;
      mag <= m8_c;
      flags <= fl7;
      byp <= bv7;
    end
  end

endmodule

// File: rtl/qnl_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to
// nearest in a final stage. Carries a sideband vector. Depends on qnl_pkg.
module qnl_sqrt import qnl_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [SUM_W-1:0] radicand,
  input  logic [SIDE_W-1:0] side_in,
  output logic out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int N = RAW_ROOT_W;

  logic v_q [N];
  logic [SUM_W-1:0] x_q [N];
  logic [RAW_ROOT_W-1:0] r_q [N];
  logic [REM_W-1:0] rem_q [N];
  logic [SIDE_W-1:0] side_q [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic v_p;
    logic [SUM_W-1:0] x_p;
    logic [RAW_ROOT_W-1:0] r_p;
    logic [REM_W-1:0] rem_p;
    logic [SIDE_W-1:0] side_p;
    logic [REM_W+1:0] rem2, trial;
    logic ge;

    if (j == 0) begin : g_src
      assign v_p = in_valid;
      assign x_p = radicand;
      assign r_p = '0;
      assign rem_p = '0;
      assign side_p = side_in;
    end else begin : g_src
      assign v_p = v_q[j-1];
      assign x_p = x_q[j-1];
      assign r_p = r_q[j-1];
      assign rem_p = rem_q[j-1];
      assign side_p = side_q[j-1];
    end

    // Bring down two bits and try the next root bit
    assign rem2 = {rem_p, x_p[SUM_W-1 -: 2]};
    assign trial = (REM_W + 2)'({r_p, 2'b01});
    assign ge = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[j] <= x_p << 2;
        r_q[j] <= {r_p[RAW_ROOT_W-2:0], ge};
        rem_q[j] <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
        side_q[j] <= side_p;
      end
    end
  end

  // Round: step up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= ROOT_W'(r_q[N-1]) +
              ((rem_q[N-1] > REM_W'(r_q[N-1])) ? ROOT_W'(1) : ROOT_W'(0));
      side_out <= side_q[N-1];
    end
  end

endmodule

// File: rtl/qnl_div.sv
// Pipelined four-lane restoring divider, one quotient bit per stage,
// dividing each scaled magnitude by the shared root. Depends on qnl_pkg.
module qnl_div import qnl_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [ROOT_W-1:0] root,
  input  logic [NMAG_W-1:0] mag [LANES],
  input  logic [SIDE_W-1:0] side_in,
  output logic out_valid,
  output logic [COMPONENT_BITS:0] quot [LANES],
  output logic [SIDE_W-1:0] side_out
);

  localparam int F = COMPONENT_BITS - 1;
  localparam int QB = COMPONENT_BITS + 1;
  localparam int NW = NMAG_W + COMPONENT_BITS;

  // Prepare stage: numerator = mag * 2^F + root / 2
  logic v0;
  logic [ROOT_W-1:0] d0;
  logic [ROOT_W-1:0] rem0 [LANES];
  logic [QB-1:0] lo0 [LANES];
  logic [SIDE_W-1:0] side0;
  logic [NW-1:0] num [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      num[i] = NW'({mag[i], {F{1'b0}}}) + NW'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= root;
      for (int i = 0; i < LANES; i++) begin
        rem0[i] <= ROOT_W'(num[i][NW-1:QB]);
        lo0[i] <= num[i][QB-1:0];
      end
      side0 <= side_in;
    end
  end

  logic v_q [QB];
  logic [ROOT_W-1:0] d_q [QB];
  logic [ROOT_W-1:0] rem_q [QB][LANES];
  logic [QB-1:0] lo_q [QB][LANES];
  logic [SIDE_W-1:0] side_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic v_p;
    logic [ROOT_W-1:0] d_p;
    logic [ROOT_W-1:0] rem_p [LANES];
    logic [QB-1:0] lo_p [LANES];
    logic [SIDE_W-1:0] side_p;

    if (j == 0) begin : g_src
      assign v_p = v0;
      assign d_p = d0;
      assign rem_p = rem0;
      assign lo_p = lo0;
      assign side_p = side0;
    end else begin : g_src
      assign v_p = v_q[j-1];
      assign d_p = d_q[j-1];
      assign rem_p = rem_q[j-1];
      assign lo_p = lo_q[j-1];
      assign side_p = side_q[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_p;
      end
    end

    // Shift in the next numerator bit, subtract where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < LANES; i++) begin
          logic [ROOT_W:0] rem2;
          logic ge;
          rem2 = {rem_p[i], lo_p[i][QB-1]};
          ge = rem2 >= {1'b0, d_p};
          rem_q[j][i] <= ge ? ROOT_W'(rem2 - {1'b0, d_p}) : ROOT_W'(rem2);
          lo_q[j][i] <= {lo_p[i][QB-2:0], ge};
        end
        d_q[j] <= d_p;
        side_q[j] <= side_p;
      end
    end
  end

  assign out_valid = v_q[QB-1];
  assign quot = lo_q[QB-1];
  assign side_out = side_q[QB-1];

endmodule

// File: rtl/quaternion_nlerp.sv
// Normalised linear blend of two quaternions (Q1.15 by default) with a Q1.16
// weight, one item accepted per cycle when the output is not stalled. The
// pipeline has eight front stages for products, blend, squares and the
// normalising shift, 32 stages of the bit-per-stage square root with its
// rounding stage, COMPONENT_BITS + 2 stages of the four-lane divider and one
// output register. A stall at the output freezes the whole pipeline. Weights
// of zero, or of one and above, pass the chosen input through; blends whose
// sum of squares is at or below the threshold give zeros with the degenerate
// flag. Depends on qnl_pkg, qnl_if, qnl_front, qnl_sqrt, qnl_div.
module quaternion_nlerp import qnl_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [THR_W-1:0] cfg_data,
  qnl_in_if.sink blend_in,
  qnl_out_if.source blend_out
);

  localparam int CB = COMPONENT_BITS;
  localparam int F = CB - 1;
  localparam int BYP_W = LANES * CB;
  localparam int MAGS_W = LANES * NMAG_W;
  localparam int SQ_SIDE_W = FLAGS_W + BYP_W + MAGS_W;
  localparam int DV_SIDE_W = FLAGS_W + BYP_W;
  localparam logic [CB:0] QMAX = {2'b00, {F{1'b1}}};

  logic adv;
  logic [THR_W-1:0] threshold;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  // Advance everything unless a result waits at the output
  assign adv = !blend_out.valid || blend_out.ready;
  assign blend_in.ready = adv;

  // Front stages
  logic signed [CB-1:0] first [LANES];
  logic signed [CB-1:0] second [LANES];
  logic fr_valid;
  logic [SUM_W-1:0] fr_sum;
  logic [NMAG_W-1:0] fr_mag [LANES];
  qnl_flags_t fr_flags;
  logic [BYP_W-1:0] fr_byp;

  assign first[0] = blend_in.first_x;
  assign first[1] = blend_in.first_y;
  assign first[2] = blend_in.first_z;
  assign first[3] = blend_in.first_w;
  assign second[0] = blend_in.second_x;
  assign second[1] = blend_in.second_y;
  assign second[2] = blend_in.second_z;
  assign second[3] = blend_in.second_w;

  qnl_front #(.COMPONENT_BITS(CB)) u_front (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(blend_in.valid),
    .first(first), .second(second),
    .weight(blend_in.weight),
    .threshold(threshold),
    .out_valid(fr_valid), .norm_sum(fr_sum), .mag(fr_mag),
    .flags(fr_flags), .byp(fr_byp)
  );

  // Square root, magnitudes ride along
  logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;
  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [NMAG_W-1:0] sq_mag [LANES];
  qnl_flags_t sq_flags;
  logic [BYP_W-1:0] sq_byp;

  assign sq_side_in = {fr_flags, fr_byp, fr_mag[3], fr_mag[2], fr_mag[1], fr_mag[0]};

  qnl_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(fr_valid), .radicand(fr_sum), .side_in(sq_side_in),
    .out_valid(sq_valid), .root(sq_root), .side_out(sq_side_out)
  );

  always_comb begin
    for (int i = 0; i < LANES; i++) sq_mag[i] = sq_side_out[i*NMAG_W +: NMAG_W];
    sq_byp = sq_side_out[MAGS_W +: BYP_W];
    sq_flags = sq_side_out[MAGS_W + BYP_W +: FLAGS_W];
  end

  // Division by the root
  logic dv_valid;
  logic [CB:0] dv_quot [LANES];
  logic [DV_SIDE_W-1:0] dv_side;
  qnl_flags_t dv_flags;
  logic [BYP_W-1:0] dv_byp;

  qnl_div #(.COMPONENT_BITS(CB), .SIDE_W(DV_SIDE_W)) u_div (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(sq_valid), .root(sq_root), .mag(sq_mag),
    .side_in({sq_flags, sq_byp}),
    .out_valid(dv_valid), .quot(dv_quot), .side_out(dv_side)
  );

  assign dv_byp = dv_side[BYP_W-1:0];
  assign dv_flags = dv_side[BYP_W +: FLAGS_W];

  // Saturate, apply sign, pick pass-through or zeros
  logic signed [CB-1:0] res [LANES];
  logic res_degen;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [CB:0] sat;
      sat = (dv_quot[i] > QMAX) ? QMAX : dv_quot[i];
      if (dv_flags.bypass) begin
        res[i] = dv_byp[i*CB +: CB];
      end else if (dv_flags.degenerate) begin
        res[i] = '0;
      end else begin
        res[i] = dv_flags.neg[i] ? -$signed(sat[CB-1:0]) : $signed(sat[CB-1:0]);
      end
    end
    res_degen = dv_flags.degenerate && !dv_flags.bypass;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_out.valid <= 1'b0;
    end else if (adv) begin
      blend_out.valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blend_out.out_x <= res[0];
      blend_out.out_y <= res[1];
      blend_out.out_z <= res[2];
      blend_out.out_w <= res[3];
      blend_out.degenerate <= res_degen;
    end
  end

endmodule

// File: rtl/qnl_checker.sv
// Port-level checks for the quaternion normalised blend, bound to the top.
// Depends on quaternion_nlerp and its channel interfaces.
module qnl_checker #(
  parameter int COMPONENT_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [COMPONENT_BITS-1:0] out_x,
  input logic signed [COMPONENT_BITS-1:0] out_y,
  input logic signed [COMPONENT_BITS-1:0] out_z,
  input logic signed [COMPONENT_BITS-1:0] out_w,
  input logic out_degenerate
);

  localparam logic signed [COMPONENT_BITS-1:0] MOST_NEG = {1'b1, {(COMPONENT_BITS-1){1'b0}}};

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled item
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(out_w) && $stable(out_degenerate))
    else $error("stalled item changed");

  // Input is taken exactly when the output can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output state");

  // A degenerate item carries zeros
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degenerate |-> out_x == '0 && out_y == '0 &&
      out_z == '0 && out_w == '0)
    else $error("degenerate item with nonzero components");

  // Results stay within the symmetric range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_x != MOST_NEG && out_y != MOST_NEG &&
      out_z != MOST_NEG && out_w != MOST_NEG)
    else $error("component at most negative code");

endmodule

bind quaternion_nlerp qnl_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_qnl_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(blend_in.ready),
  .out_valid(blend_out.valid),
  .out_ready(blend_out.ready),
  .out_x(blend_out.out_x),
  .out_y(blend_out.out_y),
  .out_z(blend_out.out_z),
  .out_w(blend_out.out_w),
  .out_degenerate(blend_out.degenerate)
);

// File: verif/quaternion_nlerp_tb.sv
// Self-checking testbench for quaternion_nlerp: directed and random blends,
// threshold changes between phases, random idling and a long output stall.
// Depends on qnl_pkg, qnl_if and the quaternion_nlerp RTL.
`timescale 1ns / 1ps

module quaternion_nlerp_tb;
  import qnl_pkg::*;

  localparam int CB = 16;
  localparam int CF = CB - 1;
  localparam longint CMAXV = (64'sd1 <<< CF) - 1;
  localparam int LATENCY = 43 + CB;

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, az, aw;
    logic signed [CB-1:0] cx, cy, cz, cw;
    logic [WEIGHT_W-1:0] wt;
  } blend_req_t;

  typedef struct packed {
    logic signed [CB-1:0] x, y, z, w;
    logic degen;
  } blend_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;

  qnl_in_if #(.COMPONENT_BITS(CB)) blend_in ();
  qnl_out_if #(.COMPONENT_BITS(CB)) blend_out ();

  quaternion_nlerp #(.COMPONENT_BITS(CB)) u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .blend_in(blend_in.sink), .blend_out(blend_out.source)
  );

  always #2 clk = ~clk;

  blend_req_t pending_q[$];
  blend_res_t expected_q[$];
  logic [THR_W-1:0] threshold = THR_RESET;
  int errors = 0;
  int checked = 0;
  int degen_seen = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  int out_gap = 0;
  bit stim_done = 1'b0;

  // Clamp the most negative code to the symmetric range
  function automatic longint load_c(logic signed [CB-1:0] v);
    longint s;
    s = v;
    if (s < -CMAXV) s = -CMAXV;
    return s;
  endfunction

  function automatic logic [CB-1:0] sat_c(longint v);
    if (v > CMAXV) v = CMAXV;
    if (v < -CMAXV) v = -CMAXV;
    return v[CB-1:0];
  endfunction

  // Integer square root rounded to nearest
  function automatic longint unsigned root_rnd(longint unsigned x);
    longint unsigned rem, r, b;
    rem = x; r = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic blend_res_t predict_blend(blend_req_t q);
    longint a[4], c[4], p, cc, bl;
    longint unsigned mg[4], psum, nsum, sum, r, qt;
    bit ng[4], flip;
    longint unsigned wv;
    logic [CB-1:0] o[4];
    blend_res_t res;
    int sh;
    sh = CF + 16 - INNER_FRAC;
    wv = q.wt;
    if (wv > WEIGHT_ONE) wv = WEIGHT_ONE;
    a[0] = load_c(q.ax); a[1] = load_c(q.ay); a[2] = load_c(q.az); a[3] = load_c(q.aw);
    c[0] = load_c(q.cx); c[1] = load_c(q.cy); c[2] = load_c(q.cz); c[3] = load_c(q.cw);
    res.degen = 1'b0;
    if (wv == 0 || wv == WEIGHT_ONE) begin
      for (int i = 0; i < 4; i++) o[i] = sat_c(wv == 0 ? a[i] : c[i]);
    end else begin
      psum = 0; nsum = 0; sum = 0;
      for (int i = 0; i < 4; i++) begin
        p = a[i] * c[i];
        if (p >= 0) psum += p; else nsum += -p;
      end
      flip = nsum > psum;
      for (int i = 0; i < 4; i++) begin
        cc = flip ? -c[i] : c[i];
        bl = longint'(65536 - wv) * a[i] + longint'(wv) * cc;
        ng[i] = bl < 0;
        mg[i] = ng[i] ? -bl : bl;
        if (sh > 0) mg[i] = (mg[i] + (64'd1 << (sh - 1))) >> sh;
        else mg[i] = mg[i] << -sh;
        sum += mg[i] * mg[i];
      end
      if (sum <= (longint'(threshold) << 30)) begin
        for (int i = 0; i < 4; i++) o[i] = '0;
        res.degen = 1'b1;
      end else begin
        while (sum < (64'd1 << 60)) begin
          sum <<= 2;
          for (int i = 0; i < 4; i++) mg[i] <<= 1;
        end
        r = root_rnd(sum);
        for (int i = 0; i < 4; i++) begin
          qt = (mg[i] * (64'd1 << CF) + (r >> 1)) / r;
          if (qt > CMAXV) qt = CMAXV;
          o[i] = sat_c(ng[i] ? -longint'(qt) : longint'(qt));
        end
      end
    end
    res.x = o[0]; res.y = o[1]; res.z = o[2]; res.w = o[3];
    return res;
  endfunction

  function automatic logic signed [CB-1:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh8001;
      3: return CB'($urandom_range(0, 8) - 4);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic blend_req_t rnd_req();
    blend_req_t q;
    q.ax = rnd_comp(); q.ay = rnd_comp(); q.az = rnd_comp(); q.aw = rnd_comp();
    q.cx = rnd_comp(); q.cy = rnd_comp(); q.cz = rnd_comp(); q.cw = rnd_comp();
    case ($urandom_range(0, 9))
      0: q.wt = '0;
      1: q.wt = WEIGHT_ONE;
      2: q.wt = WEIGHT_W'($urandom_range(65537, 131071));
      3: q.wt = WEIGHT_W'($urandom_range(1, 3));
      // opposite quaternions at half weight exercise the shortest-path flip
      4: begin
        q.cx = -q.ax; q.cy = -q.ay; q.cz = -q.az; q.cw = -q.aw;
        q.wt = 17'h8000;
      end
      default: q.wt = WEIGHT_W'($urandom_range(1, 65535));
    endcase
    return q;
  endfunction

  function automatic blend_req_t mk_req(int ax, int ay, int az, int aw,
                                        int cx, int cy, int cz, int cw, int wt);
    blend_req_t q;
    q.ax = CB'(ax); q.ay = CB'(ay); q.az = CB'(az); q.aw = CB'(aw);
    q.cx = CB'(cx); q.cy = CB'(cy); q.cz = CB'(cz); q.cw = CB'(cw);
    q.wt = WEIGHT_W'(wt);
    return q;
  endfunction

  // Write the threshold once the pipeline has drained
  task automatic set_threshold(logic [THR_W-1:0] v);
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    threshold = v;
  endtask

  // Driver: offer items with random gaps, predict on acceptance
  int in_gap = 0;
  initial begin
    blend_in.valid = 1'b0;
    {blend_in.first_x, blend_in.first_y, blend_in.first_z, blend_in.first_w} = '0;
    {blend_in.second_x, blend_in.second_y, blend_in.second_z, blend_in.second_w} = '0;
    blend_in.weight = '0;
  end

  always @(posedge clk) begin
    if (!rst && blend_in.valid && blend_in.ready) begin
      expected_q.push_back(predict_blend(pending_q.pop_front()));
      in_gap <= $urandom_range(0, 7) * $urandom_range(0, 1);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      blend_in.valid <= 1'b0;
    end else if (in_gap > 0 && !(blend_in.valid && !blend_in.ready)) begin
      in_gap <= in_gap - 1;
      blend_in.valid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      blend_in.valid <= 1'b1;
      blend_in.first_x <= pending_q[0].ax;
      blend_in.first_y <= pending_q[0].ay;
      blend_in.first_z <= pending_q[0].az;
      blend_in.first_w <= pending_q[0].aw;
      blend_in.second_x <= pending_q[0].cx;
      blend_in.second_y <= pending_q[0].cy;
      blend_in.second_z <= pending_q[0].cz;
      blend_in.second_w <= pending_q[0].cw;
      blend_in.weight <= pending_q[0].wt;
    end else begin
      blend_in.valid <= 1'b0;
    end
  end

  // Long hold-off: count the stalled cycles once asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cycles <= 300;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Draw the receiver's wait for the next item on each acceptance
  always @(posedge clk) begin
    if (!rst && blend_out.valid && blend_out.ready) begin
      out_gap <= $urandom_range(0, 7);
    end
  end

  // Receiver ready: per-item waits, plus the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      blend_out.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      blend_out.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      blend_out.ready <= 1'b0;
    end else begin
      blend_out.ready <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    blend_res_t got, exp_r;
    if (!rst && blend_out.valid && blend_out.ready) begin
      got = {blend_out.out_x, blend_out.out_y, blend_out.out_z, blend_out.out_w,
             blend_out.degenerate};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (got.degen) degen_seen++;
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("ERROR result %0d: expected %p got %p",
                                     checked, exp_r, got);
        end
      end
    end
  end

  // Stimulus phases
  initial begin
    blend_out.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: weight extremes, clamping, shortest path, degenerate
    pending_q.push_back(mk_req(32767, -32768, 0, 1, -5, 6, 7, 8, 0));
    pending_q.push_back(mk_req(1, 2, 3, 4, -32768, 32767, -1, 0, 65536));
    pending_q.push_back(mk_req(1, 2, 3, 4, -32768, 32767, -1, 0, 131071));
    pending_q.push_back(mk_req(1, 2, 3, 4, 5, 6, 7, 8, 65537));
    pending_q.push_back(mk_req(32767, 0, 0, 0, 0, 32767, 0, 0, 32768));
    pending_q.push_back(mk_req(32767, 0, 0, 0, -32767, 0, 0, 0, 32768));
    pending_q.push_back(mk_req(32767, 0, 0, 0, -32768, 0, 0, 0, 1));
    pending_q.push_back(mk_req(32767, 0, 0, 0, 0, 32767, 0, 0, 65535));
    pending_q.push_back(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 100));
    pending_q.push_back(mk_req(1, 0, 0, 0, 0, 1, 0, 0, 30000));
    pending_q.push_back(mk_req(-32768, -32768, -32768, -32768,
                               32767, 32767, 32767, 32767, 40000));
    pending_q.push_back(mk_req(100, 200, -300, 400, 400, 300, 200, 100, 1));
    pending_q.push_back(mk_req(16384, 16384, 16384, 16384,
                               -16384, 16384, -16384, 16384, 20000));
    pending_q.push_back(mk_req(32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767, 12345));

    // Random, with the threshold swept through its extremes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: set_threshold('0);
        2: set_threshold(32'hffffffff);
        3: set_threshold($urandom_range(0, 32'h4000_0000));
        default: ;
      endcase
      if (ph == 1) begin
        for (int i = 0; i < 60; i++) pending_q.push_back(rnd_req());
        wait (pending_q.size() < 50);
        hold_req = 1'b1;
      end
      for (int i = 0; i < 120; i++) pending_q.push_back(rnd_req());
    end
    wait (pending_q.size() == 0);
    stim_done = 1'b1;
  end

  // Completion
  initial begin
    wait (stim_done);
    wait (expected_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d blends (%0d degenerate) over four threshold settings.",
             checked, degen_seen);
    if (errors == 0) begin
      $display("PASS quaternion_nlerp");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL quaternion_nlerp");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout");
    $display("FAIL quaternion_nlerp");
    $finish;
  end

endmodule

// File: quaternion_nlerp.f
rtl/qnl_pkg.sv
rtl/qnl_if.sv
rtl/qnl_front.sv
rtl/qnl_sqrt.sv
rtl/qnl_div.sv
rtl/quaternion_nlerp.sv
rtl/qnl_checker.sv
verif/quaternion_nlerp_tb.sv
